// ----- design/wcfr_pkg.sv -----
package wcfr_pkg;

  localparam int unsigned POS_W  = 7;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MAG_W  = 16;
  localparam int unsigned DEPTH_W = 17;
  localparam int unsigned CFG_INDEX_W = 1;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_LOG_LAST = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CMD_LAST = 1'b1;

  localparam pos_t LOG_LAST_RESET = 7'd65;
  localparam pos_t CMD_LAST_RESET = 7'd12;

  localparam byte_t SYNC_BYTE = 8'h50;
  localparam byte_t TYPE_LOG  = 8'h4C;
  localparam byte_t TYPE_UP   = 8'h55;
  localparam byte_t TYPE_DOWN = 8'h44;
  localparam byte_t TYPE_STOP = 8'h43;
  localparam byte_t TYPE_AUTO = 8'h41;
  localparam byte_t TYPE_MAN  = 8'h4D;
  localparam byte_t TYPE_RSVD = 8'h42;
  localparam byte_t TYPE_BOTH = 8'h45;

  localparam pos_t POS_START   = 7'd0;
  localparam pos_t POS_TYPE    = 7'd1;
  localparam pos_t POS_SIGN    = 7'd5;
  localparam pos_t POS_DEPTH_HI = 7'd6;
  localparam pos_t POS_DEPTH_LO = 7'd7;
  localparam pos_t POS_PROFILE = 7'd18;

  typedef enum logic [3:0] {
    KIND_IGNORED    = 4'd0,
    KIND_LOG        = 4'd1,
    KIND_UP         = 4'd2,
    KIND_DOWN       = 4'd3,
    KIND_STOP       = 4'd4,
    KIND_TIMED_STOP = 4'd5,
    KIND_TIMED_DOWN = 4'd6,
    KIND_RESERVED   = 4'd7,
    KIND_BOTH       = 4'd8
  } kind_t;

  // one completed frame, classified, waiting for the back end
  typedef struct packed {
    kind_t             kind;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    byte_t             profile;
  } frame_rec_t;

  function automatic kind_t classify(input logic sync, input byte_t type_byte);
    kind_t k;
    k = KIND_IGNORED;
    if (sync) begin
      case (type_byte)
        TYPE_LOG:  k = KIND_LOG;
        TYPE_UP:   k = KIND_UP;
        TYPE_DOWN: k = KIND_DOWN;
        TYPE_STOP: k = KIND_STOP;
        TYPE_AUTO: k = KIND_TIMED_STOP;
        TYPE_MAN:  k = KIND_TIMED_DOWN;
        TYPE_RSVD: k = KIND_RESERVED;
        TYPE_BOTH: k = KIND_BOTH;
        default:   k = KIND_IGNORED;
      endcase
    end
    return k;
  endfunction

endpackage

// ----- design/wcfr_front.sv -----
module wcfr_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [wcfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wcfr_pkg::pos_t                       cfg_data,
  input  logic                                 byte_accept,
  input  wcfr_pkg::byte_t                      rx_byte,
  output logic                                 push,
  output wcfr_pkg::frame_rec_t                 push_rec
);

  wcfr_pkg::pos_t  log_last, cmd_last;
  wcfr_pkg::pos_t  pos, last;
  logic            sync;
  wcfr_pkg::byte_t type_byte, sign_byte, hi_byte, lo_byte, prof_byte;

  wcfr_pkg::pos_t  pos_eff, last_next, pos_next;
  logic            sync_next;
  wcfr_pkg::byte_t type_next, sign_next, hi_next, lo_next, prof_next;
  logic            is_sync, done;

  always_comb begin
    is_sync   = (rx_byte == wcfr_pkg::SYNC_BYTE);
    // a sync byte always restarts the frame
    pos_eff   = is_sync ? wcfr_pkg::POS_START : pos;
    last_next = is_sync ? '0 : last;
    sync_next = sync;
    type_next = type_byte;
    sign_next = sign_byte;
    hi_next   = hi_byte;
    lo_next   = lo_byte;
    prof_next = prof_byte;
    case (pos_eff)
      wcfr_pkg::POS_START: sync_next = is_sync;
      wcfr_pkg::POS_TYPE: begin
        type_next = rx_byte;
        last_next = (rx_byte == wcfr_pkg::TYPE_LOG) ? log_last : cmd_last;
      end
      wcfr_pkg::POS_SIGN:     sign_next = rx_byte;
      wcfr_pkg::POS_DEPTH_HI: hi_next   = rx_byte;
      wcfr_pkg::POS_DEPTH_LO: lo_next   = rx_byte;
      wcfr_pkg::POS_PROFILE:  prof_next = rx_byte;
      default: ;
    endcase
    done     = (last_next != '0) && (pos_eff == last_next);
    pos_next = done ? wcfr_pkg::POS_START : pos_eff + 7'd1;
  end

  assign push             = byte_accept && done;
  assign push_rec.kind    = wcfr_pkg::classify(sync_next, type_next);
  assign push_rec.neg     = (sign_next != '0);
  assign push_rec.mag     = {hi_next, lo_next};
  assign push_rec.profile = prof_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_last  <= wcfr_pkg::LOG_LAST_RESET;
      cmd_last  <= wcfr_pkg::CMD_LAST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wcfr_pkg::CFG_LOG_LAST: log_last <= cfg_data;
        wcfr_pkg::CFG_CMD_LAST: cmd_last <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      last      <= '0;
      sync      <= 1'b0;
      type_byte <= '0;
      sign_byte <= '0;
      hi_byte   <= '0;
      lo_byte   <= '0;
      prof_byte <= '0;
    end else if (byte_accept) begin
      pos       <= pos_next;
      last      <= done ? '0 : last_next;
      sync      <= sync_next;
      type_byte <= type_next;
      sign_byte <= sign_next;
      hi_byte   <= hi_next;
      lo_byte   <= lo_next;
      prof_byte <= prof_next;
    end
  end

endmodule

// ----- design/wcfr_queue.sv -----
module wcfr_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  wcfr_pkg::frame_rec_t  push_rec,
  output logic                  full,
  output logic                  head_valid,
  output wcfr_pkg::frame_rec_t  head_rec,
  input  logic                  pop
);

  // two slots, head in slot0, shifts on pop
  wcfr_pkg::frame_rec_t slot0, slot1;
  logic [1:0]           count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_rec   = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) slot0 <= push_rec;
        else               slot1 <= push_rec;
      end
      2'b01: slot0 <= slot1;
      2'b11: begin
        if (count == 2'd1) begin
          slot0 <= push_rec;
        end else begin
          slot0 <= slot1;
          slot1 <= push_rec;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- design/wcfr_back.sv -----
module wcfr_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  head_valid,
  input  wcfr_pkg::frame_rec_t                  head_rec,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [3:0]                            frame_kind,
  output logic                                  flags_update,
  output logic                                  drive_down,
  output logic                                  drive_up,
  output logic                                  timed_mode,
  output logic signed [wcfr_pkg::DEPTH_W-1:0]   depth_mm,
  output logic                                  profile_update,
  output wcfr_pkg::byte_t                       profile
);

  logic upd, dn, up, tm, prof_upd;
  logic [wcfr_pkg::DEPTH_W-1:0] mag_ext, depth_val;

  always_comb begin
    upd = 1'b0;
    dn  = 1'b0;
    up  = 1'b0;
    tm  = 1'b0;
    prof_upd = 1'b0;
    case (head_rec.kind)
      wcfr_pkg::KIND_LOG:        prof_upd = 1'b1;
      wcfr_pkg::KIND_UP:         begin upd = 1'b1; up = 1'b1; end
      wcfr_pkg::KIND_DOWN:       begin upd = 1'b1; dn = 1'b1; end
      wcfr_pkg::KIND_STOP:       upd = 1'b1;
      wcfr_pkg::KIND_TIMED_STOP: begin upd = 1'b1; tm = 1'b1; end
      wcfr_pkg::KIND_TIMED_DOWN: begin upd = 1'b1; dn = 1'b1; tm = 1'b1; end
      wcfr_pkg::KIND_BOTH:       begin upd = 1'b1; dn = 1'b1; up = 1'b1; end
      default: ;
    endcase
    mag_ext = {1'b0, head_rec.mag};
    if (!upd)              depth_val = '0;
    else if (head_rec.neg) depth_val = '0 - mag_ext;
    else                   depth_val = mag_ext;
  end

  assign pop = head_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_kind     <= head_rec.kind;
      flags_update   <= upd;
      drive_down     <= dn;
      drive_up       <= up;
      timed_mode     <= tm;
      depth_mm       <= depth_val;
      profile_update <= prof_upd;
      profile        <= prof_upd ? head_rec.profile : '0;
    end
  end

endmodule

// ----- design/winch_command_frame_receiver.sv -----
// winch command frame receiver
// input channel: in_valid / in_ready with rx_byte, one received serial byte per item
// output channel: out_valid / out_ready with one result item per completed frame:
//   frame_kind, drive flags with depth_mm, or profile from a log frame
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is the
//   last position of a log frame, index 1 the last position of any other frame;
//   always ready; users write only while the block is idle (not enforced)
// throughput: one byte per cycle; in_ready drops only while the two-entry frame
//   queue is full, which happens only when the output side stalls
// path: the byte completing a frame is written to the queue at the edge that accepts it,
//   and the output register loads from the queue head once the output register is free
// reset: frame position and queue clear, captured frame bytes return to zero,
//   last positions return to 65 and 12
// stall: when out_ready is low the result holds in the output register, up to two
//   more completed frames wait in the queue, and bytes keep flowing in as long as
//   the queue has room
module winch_command_frame_receiver (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wcfr_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [wcfr_pkg::POS_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            rx_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [3:0]                            frame_kind,
  output logic                                  flags_update,
  output logic                                  drive_down,
  output logic                                  drive_up,
  output logic                                  timed_mode,
  output logic signed [wcfr_pkg::DEPTH_W-1:0]   depth_mm,
  output logic                                  profile_update,
  output logic [7:0]                            profile
);

  logic                 q_full, q_push, q_pop, head_valid;
  wcfr_pkg::frame_rec_t push_rec, head_rec;

  // config registers are plain flops, nothing to wait for
  assign cfg_ready = 1'b1;
  // every byte is taken unless the frame queue is full
  assign in_ready  = !q_full;

  // front: framing, field capture and frame classification
  wcfr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .byte_accept (in_valid && in_ready),
    .rx_byte     (rx_byte),
    .push        (q_push),
    .push_rec    (push_rec)
  );

  // short queue of completed frames between front and back
  wcfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_rec   (push_rec),
    .full       (q_full),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (q_pop)
  );

  // back: flag decode, signed depth and the output register
  wcfr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_rec       (head_rec),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_kind     (frame_kind),
    .flags_update   (flags_update),
    .drive_down     (drive_down),
    .drive_up       (drive_up),
    .timed_mode     (timed_mode),
    .depth_mm       (depth_mm),
    .profile_update (profile_update),
    .profile        (profile)
  );

endmodule

// ----- design/wcfr_checker.sv -----
module wcfr_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [3:0]                            frame_kind,
  input logic                                  flags_update,
  input logic                                  drive_down,
  input logic                                  drive_up,
  input logic                                  timed_mode,
  input logic signed [wcfr_pkg::DEPTH_W-1:0]   depth_mm,
  input logic                                  profile_update,
  input logic [7:0]                            profile
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_kind) && $stable(depth_mm)
      && $stable(profile))
    else $error("stalled result changed");

  a_no_update_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !flags_update |-> !drive_down && !drive_up && !timed_mode
      && depth_mm == '0)
    else $error("flags or depth set without update");

  a_profile_log: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> profile_update == (frame_kind == wcfr_pkg::KIND_LOG)
      && (profile_update || profile == '0))
    else $error("profile update does not match a log frame");

  a_update_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && flags_update |-> frame_kind != wcfr_pkg::KIND_IGNORED
      && frame_kind != wcfr_pkg::KIND_LOG && frame_kind != wcfr_pkg::KIND_RESERVED)
    else $error("flag update from a frame kind that carries none");

endmodule

bind winch_command_frame_receiver wcfr_checker u_wcfr_checker (.*);
